// File: hdl/jta_pkg.sv
// Shared definitions for the job table: field widths, operation and status
// codes, and the result packing used on the master-side stream.
// No dependencies.
`timescale 1ns / 1ps

package jta_pkg;

	localparam int TABLE_ENTRIES_DEF = 16;

	localparam int MODE_W   = 3;
	localparam int PROC_W   = 22;
	localparam int JOB_W    = 5;
	localparam int STATE_W  = 2;
	localparam int STATUS_W = 2;
	localparam int TDATA_W  = 32;

	localparam logic [MODE_W-1:0] MODE_ADD   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_DEL   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_SETP  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SETJ  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_FINDP = 3'd4;
	localparam logic [MODE_W-1:0] MODE_FINDJ = 3'd5;
	localparam logic [MODE_W-1:0] MODE_FG    = 3'd6;
	localparam logic [MODE_W-1:0] MODE_LIST  = 3'd7;

	localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STS_NOTFOUND = 2'd1;
	localparam logic [STATUS_W-1:0] STS_FULL     = 2'd2;
	localparam logic [STATUS_W-1:0] STS_INVALID  = 2'd3;

	localparam logic [STATE_W-1:0] RUN_FG = 2'd1;

	function automatic logic [TDATA_W-1:0] pack_res(
		input logic [STATUS_W-1:0] status,
		input logic [PROC_W-1:0]   proc,
		input logic [JOB_W-1:0]    job,
		input logic [STATE_W-1:0]  st
	);
		pack_res = {1'b0, st, job, proc, status};
	endfunction

endpackage

// File: hdl/jta_table_mem.sv
// Entry store of the job table: one synchronous memory with a registered read
// port and per-entry occupancy flags that reset clears. Uses jta_pkg.
`timescale 1ns / 1ps

module jta_table_mem #(
	parameter int TABLE_ENTRIES = jta_pkg::TABLE_ENTRIES_DEF,
	parameter int AW = $clog2(TABLE_ENTRIES),
	parameter int WW = jta_pkg::PROC_W + $clog2(TABLE_ENTRIES + 1) + jta_pkg::STATE_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [WW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [WW-1:0] wr_data
);

	logic [WW-1:0]            mem_q [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] vld_q;
	logic [WW-1:0]            rdat_q;
	logic                     rvld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdat_q <= mem_q[rd_addr];
		end
	end

	// occupied while the stored process id is non-zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= |wr_data[WW-1 -: jta_pkg::PROC_W];
			end
			if (rd_en) begin
				rvld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rvld_q ? rdat_q : '0;

endmodule

// File: hdl/jta_seq.sv
// Command sequencer of the job table: walks the entry store one entry at a
// time, updates it and drives the registered result stream. Uses jta_pkg.
`timescale 1ns / 1ps

module jta_seq #(
	parameter int TABLE_ENTRIES = jta_pkg::TABLE_ENTRIES_DEF,
	parameter int AW = $clog2(TABLE_ENTRIES),
	parameter int JW = $clog2(TABLE_ENTRIES + 1),
	parameter int WW = jta_pkg::PROC_W + $clog2(TABLE_ENTRIES + 1) + jta_pkg::STATE_W
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [jta_pkg::TDATA_W-1:0] s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [jta_pkg::TDATA_W-1:0] m_tdata,
	output logic                        m_tlast,
	output logic                        rd_en,
	output logic [AW-1:0]               rd_addr,
	input  logic [WW-1:0]               rd_data,
	output logic                        wr_en,
	output logic [AW-1:0]               wr_addr,
	output logic [WW-1:0]               wr_data
);

	localparam int CW = (JW > jta_pkg::JOB_W) ? JW : jta_pkg::JOB_W;
	localparam int PW = jta_pkg::PROC_W;
	localparam int SW = jta_pkg::STATE_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_EV   = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0]                  state_q;
	logic [jta_pkg::MODE_W-1:0]  mode_q;
	logic [PW-1:0]               pid_q;
	logic [jta_pkg::JOB_W-1:0]   jid_q;
	logic [SW-1:0]               nst_q;
	logic                        bad_q;
	logic [AW-1:0]               idx_q;
	logic                        found_q;
	logic [AW-1:0]               f_idx_q;
	logic [PW-1:0]               f_proc_q;
	logic [JW-1:0]               f_job_q;
	logic [SW-1:0]               f_state_q;
	logic [JW-1:0]               mx_q;
	logic [JW-1:0]               next_q;
	logic                        out_vld_q;
	logic [jta_pkg::TDATA_W-1:0] out_data_q;
	logic                        out_last_q;

	logic [jta_pkg::MODE_W-1:0]  in_mode;
	logic [PW-1:0]               in_pid;
	logic [jta_pkg::JOB_W-1:0]   in_jid;
	logic [SW-1:0]               in_st;
	logic                        in_bad;
	logic                        accept;

	logic [PW-1:0]               d_proc;
	logic [JW-1:0]               d_job;
	logic [SW-1:0]               d_state;
	logic                        match;
	logic                        is_list;
	logic                        is_del;
	logic                        last_idx;
	logic                        space;
	logic                        stall;

	logic                        emit;
	logic                        emit_last;
	logic [jta_pkg::STATUS_W-1:0] res_status;
	logic [PW-1:0]               res_proc;
	logic [JW-1:0]               res_job;
	logic [CW-1:0]               res_job_cw;
	logic [SW-1:0]               res_state;
	logic [JW-1:0]               next_inc;
	logic [JW-1:0]               mx_inc;

	assign in_mode = s_tdata[2:0];
	assign in_pid  = s_tdata[24:3];
	assign in_jid  = s_tdata[29:25];
	assign in_st   = s_tdata[31:30];

	always_comb begin
		case (in_mode)
			jta_pkg::MODE_ADD, jta_pkg::MODE_DEL, jta_pkg::MODE_SETP,
			jta_pkg::MODE_FINDP: begin
				in_bad = (in_pid == '0);
			end
			jta_pkg::MODE_SETJ, jta_pkg::MODE_FINDJ: begin
				in_bad = (in_jid == '0);
			end
			default: begin
				in_bad = 1'b0;
			end
		endcase
	end

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	assign d_proc  = rd_data[WW-1 -: PW];
	assign d_job   = rd_data[SW +: JW];
	assign d_state = rd_data[SW-1:0];

	always_comb begin
		case (mode_q)
			jta_pkg::MODE_ADD: begin
				match = (d_proc == '0);
			end
			jta_pkg::MODE_DEL, jta_pkg::MODE_SETP, jta_pkg::MODE_FINDP: begin
				match = (d_proc == pid_q);
			end
			jta_pkg::MODE_SETJ, jta_pkg::MODE_FINDJ: begin
				match = (d_proc != '0) && (CW'(d_job) == CW'(jid_q));
			end
			jta_pkg::MODE_FG: begin
				match = (d_proc != '0) && (d_state == jta_pkg::RUN_FG);
			end
			default: begin
				match = (d_proc != '0);
			end
		endcase
	end

	assign is_list  = (mode_q == jta_pkg::MODE_LIST);
	assign is_del   = (mode_q == jta_pkg::MODE_DEL);
	assign last_idx = (idx_q == AW'(TABLE_ENTRIES - 1));
	assign space    = !out_vld_q || m_tready;
	// list: a newer occupied entry pushes out the one held back
	assign stall    = (state_q == S_EV) && is_list && match && found_q && !space;

	assign next_inc = (next_q == JW'(TABLE_ENTRIES)) ? JW'(1) : next_q + JW'(1);
	assign mx_inc   = (mx_q == JW'(TABLE_ENTRIES)) ? JW'(1) : mx_q + JW'(1);

	always_comb begin
		emit       = 1'b0;
		emit_last  = 1'b1;
		res_status = jta_pkg::STS_OK;
		res_proc   = f_proc_q;
		res_job    = f_job_q;
		res_state  = f_state_q;
		wr_en      = 1'b0;
		wr_addr    = f_idx_q;
		wr_data    = {f_proc_q, f_job_q, nst_q};
		if (state_q == S_EV) begin
			if (is_list && match && found_q && space) begin
				emit      = 1'b1;
				emit_last = 1'b0;
			end
		end else if (state_q == S_FIN && space) begin
			emit = 1'b1;
			if (bad_q) begin
				res_status = jta_pkg::STS_INVALID;
			end else if (mode_q == jta_pkg::MODE_ADD) begin
				if (found_q) begin
					res_proc  = pid_q;
					res_job   = next_q;
					res_state = nst_q;
					wr_en     = 1'b1;
					wr_data   = {pid_q, next_q, nst_q};
				end else begin
					res_status = jta_pkg::STS_FULL;
				end
			end else if (!found_q) begin
				res_status = jta_pkg::STS_NOTFOUND;
			end else begin
				case (mode_q)
					jta_pkg::MODE_DEL: begin
						wr_en   = 1'b1;
						wr_data = '0;
					end
					jta_pkg::MODE_SETP, jta_pkg::MODE_SETJ: begin
						res_state = nst_q;
						wr_en     = 1'b1;
					end
					default: begin
						wr_en = 1'b0;
					end
				endcase
			end
			if (res_status != jta_pkg::STS_OK) begin
				res_proc  = '0;
				res_job   = '0;
				res_state = '0;
			end
		end
	end

	assign res_job_cw = CW'(res_job);
	assign rd_en      = (state_q == S_RD);
	assign rd_addr    = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q  <= jta_pkg::MODE_ADD;
			bad_q   <= 1'b0;
			idx_q   <= '0;
			found_q <= 1'b0;
			mx_q    <= '0;
			next_q  <= JW'(1);
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						mode_q  <= in_mode;
						bad_q   <= in_bad;
						idx_q   <= '0;
						found_q <= 1'b0;
						mx_q    <= '0;
						state_q <= in_bad ? S_FIN : S_RD;
					end
				end
				S_RD: begin
					state_q <= S_EV;
				end
				S_EV: begin
					if (!stall) begin
						if (match && !(is_del && found_q)) begin
							found_q <= 1'b1;
						end else if (is_del && d_job > mx_q) begin
							mx_q <= d_job;
						end
						if ((match && !is_list && !is_del) || last_idx) begin
							state_q <= S_FIN;
						end else begin
							idx_q   <= idx_q + AW'(1);
							state_q <= S_RD;
						end
					end
				end
				default: begin
					if (space) begin
						if (!bad_q && found_q) begin
							if (mode_q == jta_pkg::MODE_ADD) begin
								next_q <= next_inc;
							end else if (is_del) begin
								next_q <= mx_inc;
							end
						end
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	// hold the command and the selected entry
	always_ff @(posedge clk) begin
		if (accept) begin
			pid_q <= in_pid;
			jid_q <= in_jid;
			nst_q <= in_st;
		end
		if (state_q == S_EV && !stall && match && !(is_del && found_q)) begin
			f_idx_q   <= idx_q;
			f_proc_q  <= d_proc;
			f_job_q   <= d_job;
			f_state_q <= d_state;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= jta_pkg::pack_res(res_status, res_proc,
				res_job_cw[jta_pkg::JOB_W-1:0], res_state);
			out_last_q <= emit_last;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

// File: hdl/job_table_with_id_allocation_unit.sv
// Job table with job id allocation: top level joining the sequencer and the
// entry store. Uses jta_pkg, jta_seq and jta_table_mem.
//
// Commands arrive on the slave-side stream, one transfer per command, and
// results leave on the master-side stream; tlast marks the final result of a
// command. List gives one result per occupied entry (a single not-found
// result on an empty table), every other command one. A command walks the
// table through one synchronous memory, with separate read and write ports and
// a registered read port, one entry at a time (address, then evaluate), and
// stops at the first match where the command allows it. The next command is
// accepted once the final step has handed its result to the output register.
// Add, delete and set state write the entry back in the final step. An invalid
// id skips the walk and goes straight to the final step. One command is in
// work at a time; s_tready is high only while idle.
// Reset empties the table at once through per-entry occupancy flags and sets
// the next job id to 1; no clearing pass is needed.
// When the receiver stalls, the finished result waits in the output register
// and the walk holds until that register can take the next result.
`timescale 1ns / 1ps

module job_table_with_id_allocation_unit #(
	parameter int TABLE_ENTRIES = jta_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// mode[2:0], proc_id[24:3], job_id[29:25], new_state[31:30]
	input  logic [jta_pkg::TDATA_W-1:0] s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// status[1:0], entry_proc[23:2], entry_job[28:24], entry_state[30:29], zero[31]
	output logic [jta_pkg::TDATA_W-1:0] m_tdata,
	output logic                        m_tlast
);

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int JW = $clog2(TABLE_ENTRIES + 1);
	localparam int WW = jta_pkg::PROC_W + JW + jta_pkg::STATE_W;

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [WW-1:0] rd_data;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [WW-1:0] wr_data;

	jta_seq #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.AW(AW),
		.JW(JW),
		.WW(WW)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	jta_table_mem #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.AW(AW),
		.WW(WW)
	) u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

endmodule

// File: tb/sv/job_table_with_id_allocation_unit_tb.sv
// Self-checking bench for the job table: a directed table of commands and a
// random mix of adds, deletes, state changes, lookups and listings, with every
// reply checked against a fixed expectation or the bench's predictor. Uses jta_pkg.
`timescale 1ns / 1ps

module job_table_with_id_allocation_unit_tb;

	import jta_pkg::*;

	localparam int ENTRIES    = TABLE_ENTRIES_DEF;
	localparam int N_RANDOM   = 85;
	localparam int N_DIRECTED = 25;
	localparam int CYCLE_CAP  = 200000;
	localparam int DRAIN_WAIT = 80;
	localparam int HOLD_LEN   = 250;

	localparam logic [STATE_W-1:0] RUN_UNDEF = 2'd0;
	localparam logic [STATE_W-1:0] RUN_BG    = 2'd2;
	localparam logic [STATE_W-1:0] RUN_STOP  = 2'd3;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [PROC_W-1:0]  pid;
		logic [JOB_W-1:0]   jid;
		logic [STATE_W-1:0] run;
	} cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] sts;
		logic [PROC_W-1:0]   pid;
		logic [JOB_W-1:0]    jid;
		logic [STATE_W-1:0]  run;
		logic                tail;
	} reply_t;

	typedef struct packed {
		cmd_t   c;
		logic   typed;
		reply_t r;
	} row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [TDATA_W-1:0]  s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [TDATA_W-1:0]  m_tdata;
	logic                m_tlast;

	// predictor state
	logic [PROC_W-1:0]   jt_pid [ENTRIES];
	logic [JOB_W-1:0]    jt_jid [ENTRIES];
	logic [STATE_W-1:0]  jt_run [ENTRIES];
	int                  jt_next_id;

	reply_t              replies_due[$];
	row_t                dir_rows [N_DIRECTED];
	logic [PROC_W-1:0]   pid_pool [12];

	int  errors = 0;
	int  n_cmds = 0;
	int  n_replies = 0;
	int  n_full = 0;
	int  n_lists = 0;
	int  cycles = 0;
	bit  calm_tx = 1'b0;

	job_table_with_id_allocation_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_CAP) begin
			$display("%0t: timeout, %0d replies still due", $time, replies_due.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic reply_t miss(input logic [STATUS_W-1:0] sts);
		reply_t r;
		r = '0;
		r.sts = sts;
		r.tail = 1'b1;
		return r;
	endfunction

	function automatic reply_t slot_reply(input int i, input logic tail);
		reply_t r;
		r.sts = STS_OK;
		r.pid = jt_pid[i];
		r.jid = jt_jid[i];
		r.run = jt_run[i];
		r.tail = tail;
		return r;
	endfunction

	function automatic void jt_clear();
		for (int i = 0; i < ENTRIES; i++) begin
			jt_pid[i] = '0;
			jt_jid[i] = '0;
			jt_run[i] = '0;
		end
		jt_next_id = 1;
	endfunction

	// Work out the replies of one command and advance the table copy.
	function automatic void job_table_replies(input cmd_t c, ref reply_t q[$]);
		int hit;
		int mx;
		hit = -1;
		mx = 0;
		case (c.mode)
			MODE_ADD: begin
				if (c.pid == '0) begin
					q.push_back(miss(STS_INVALID));
				end else begin
					for (int i = 0; i < ENTRIES && hit < 0; i++)
						if (jt_pid[i] == '0) hit = i;
					if (hit < 0) begin
						q.push_back(miss(STS_FULL));
						n_full++;
					end else begin
						jt_pid[hit] = c.pid;
						jt_run[hit] = c.run;
						jt_jid[hit] = JOB_W'(jt_next_id);
						jt_next_id = (jt_next_id >= ENTRIES) ? 1 : jt_next_id + 1;
						q.push_back(slot_reply(hit, 1'b1));
					end
				end
			end
			MODE_DEL, MODE_SETP, MODE_FINDP: begin
				if (c.pid == '0) begin
					q.push_back(miss(STS_INVALID));
				end else begin
					for (int i = 0; i < ENTRIES && hit < 0; i++)
						if (jt_pid[i] == c.pid) hit = i;
					if (hit < 0) begin
						q.push_back(miss(STS_NOTFOUND));
					end else if (c.mode == MODE_DEL) begin
						q.push_back(slot_reply(hit, 1'b1));
						jt_pid[hit] = '0;
						jt_jid[hit] = '0;
						jt_run[hit] = '0;
						for (int i = 0; i < ENTRIES; i++)
							if (jt_jid[i] > mx) mx = jt_jid[i];
						jt_next_id = (mx + 1 > ENTRIES) ? 1 : mx + 1;
					end else begin
						if (c.mode == MODE_SETP) jt_run[hit] = c.run;
						q.push_back(slot_reply(hit, 1'b1));
					end
				end
			end
			MODE_SETJ, MODE_FINDJ: begin
				if (c.jid == '0) begin
					q.push_back(miss(STS_INVALID));
				end else begin
					for (int i = 0; i < ENTRIES && hit < 0; i++)
						if (jt_pid[i] != '0 && jt_jid[i] == c.jid) hit = i;
					if (hit < 0) begin
						q.push_back(miss(STS_NOTFOUND));
					end else begin
						if (c.mode == MODE_SETJ) jt_run[hit] = c.run;
						q.push_back(slot_reply(hit, 1'b1));
					end
				end
			end
			MODE_FG: begin
				for (int i = 0; i < ENTRIES && hit < 0; i++)
					if (jt_pid[i] != '0 && jt_run[i] == RUN_FG) hit = i;
				if (hit < 0) q.push_back(miss(STS_NOTFOUND));
				else q.push_back(slot_reply(hit, 1'b1));
			end
			default: begin
				n_lists++;
				for (int i = 0; i < ENTRIES; i++)
					if (jt_pid[i] != '0) begin
						q.push_back(slot_reply(i, 1'b0));
						hit = i;
					end
				if (hit < 0) q.push_back(miss(STS_NOTFOUND));
				else q[q.size()-1].tail = 1'b1;
			end
		endcase
	endfunction

	function automatic cmd_t mk_cmd(input logic [MODE_W-1:0] mode,
			input logic [PROC_W-1:0] pid, input logic [JOB_W-1:0] jid,
			input logic [STATE_W-1:0] run);
		cmd_t c;
		c.mode = mode;
		c.pid = pid;
		c.jid = jid;
		c.run = run;
		return c;
	endfunction

	function automatic row_t chk(input cmd_t c);
		row_t w;
		w.c = c;
		w.typed = 1'b0;
		w.r = '0;
		return w;
	endfunction

	function automatic row_t fixed(input cmd_t c, input logic [STATUS_W-1:0] sts,
			input logic [PROC_W-1:0] pid, input logic [JOB_W-1:0] jid,
			input logic [STATE_W-1:0] run);
		row_t w;
		w.c = c;
		w.typed = 1'b1;
		w.r.sts = sts;
		w.r.pid = pid;
		w.r.jid = jid;
		w.r.run = run;
		w.r.tail = 1'b1;
		return w;
	endfunction

	// Early on fill the table, late on drain it, in between mix everything.
	function automatic cmd_t random_cmd(input int idx);
		cmd_t c;
		int   roll;
		roll = $urandom_range(99);
		if (idx < 20)
			c.mode = (roll < 80) ? MODE_ADD : MODE_W'($urandom_range(7));
		else if (idx >= 62)
			c.mode = (roll < 50) ? MODE_DEL : MODE_W'($urandom_range(7));
		else if (roll < 30) c.mode = MODE_ADD;
		else if (roll < 45) c.mode = MODE_DEL;
		else if (roll < 55) c.mode = MODE_SETP;
		else if (roll < 65) c.mode = MODE_SETJ;
		else if (roll < 75) c.mode = MODE_FINDP;
		else if (roll < 85) c.mode = MODE_FINDJ;
		else if (roll < 90) c.mode = MODE_FG;
		else c.mode = MODE_LIST;
		roll = $urandom_range(99);
		if (roll < 82) c.pid = pid_pool[$urandom_range(11)];
		else if (roll < 96) c.pid = PROC_W'($urandom());
		else c.pid = '0;
		roll = $urandom_range(99);
		if (roll < 75) c.jid = JOB_W'($urandom_range(ENTRIES, 1));
		else if (roll < 95) c.jid = JOB_W'($urandom_range(31, ENTRIES + 1));
		else c.jid = '0;
		c.run = STATE_W'($urandom_range(3));
		return c;
	endfunction

	task automatic send_cmd(input row_t w);
		reply_t q[$];
		if (!calm_tx && $urandom_range(99) < 7) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {w.c.run, w.c.jid, w.c.pid, w.c.mode};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		job_table_replies(w.c, q);
		if (w.typed) replies_due.push_back(w.r);
		else foreach (q[k]) replies_due.push_back(q[k]);
		n_cmds++;
		@(negedge clk);
	endtask

	// receiver: random stalls, one long hold-off, quiet stretch in the middle
	initial begin : rx
		int hold_left;
		bit held;
		reply_t got;
		reply_t want;
		hold_left = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.sts = m_tdata[1:0];
				got.pid = m_tdata[23:2];
				got.jid = m_tdata[28:24];
				got.run = m_tdata[30:29];
				got.tail = m_tlast;
				n_replies++;
				if (replies_due.size() == 0) begin
					errors++;
					$display("%0t: reply with nothing due: sts %0d pid %0h job %0d %s",
						$time, got.sts, got.pid, got.jid,
						$sformatf("run %0d last %0b", got.run, got.tail));
				end else begin
					want = replies_due.pop_front();
					if (got !== want) begin
						errors++;
						$display("%0t: expected sts %0d pid %0h job %0d run %0d last %0b,",
							$time, want.sts, want.pid, want.jid, want.run, want.tail);
						$display("%0t: got      sts %0d pid %0h job %0d run %0d last %0b",
							$time, got.sts, got.pid, got.jid, got.run, got.tail);
					end
				end
			end
			@(negedge clk);
			if (!held && n_replies >= 30) begin
				held = 1'b1;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (n_replies >= 80 && n_replies < 160) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= 7);
			end
		end
	end

	initial begin : tx
		dir_rows[0]  = fixed(mk_cmd(MODE_LIST, '0, '0, RUN_UNDEF), STS_NOTFOUND, '0, '0, '0);
		dir_rows[1]  = fixed(mk_cmd(MODE_FG, '0, '0, RUN_UNDEF), STS_NOTFOUND, '0, '0, '0);
		dir_rows[2]  = fixed(mk_cmd(MODE_ADD, '0, 5'd3, RUN_STOP), STS_INVALID, '0, '0, '0);
		dir_rows[3]  = fixed(mk_cmd(MODE_DEL, '0, 5'd1, RUN_UNDEF), STS_INVALID, '0, '0, '0);
		dir_rows[4]  = fixed(mk_cmd(MODE_SETP, '0, 5'd1, RUN_FG), STS_INVALID, '0, '0, '0);
		dir_rows[5]  = fixed(mk_cmd(MODE_FINDP, '0, 5'd31, RUN_UNDEF), STS_INVALID, '0, '0, '0);
		dir_rows[6]  = fixed(mk_cmd(MODE_SETJ, 22'd7, '0, RUN_BG), STS_INVALID, '0, '0, '0);
		dir_rows[7]  = fixed(mk_cmd(MODE_FINDJ, 22'd7, '0, RUN_UNDEF), STS_INVALID, '0, '0, '0);
		dir_rows[8]  = fixed(mk_cmd(MODE_ADD, 22'd1, '0, RUN_STOP), STS_OK, 22'd1, 5'd1, RUN_STOP);
		dir_rows[9]  = fixed(mk_cmd(MODE_ADD, 22'h3FFFFF, 5'd31, RUN_FG), STS_OK,
			22'h3FFFFF, 5'd2, RUN_FG);
		dir_rows[10] = fixed(mk_cmd(MODE_ADD, 22'h2AAAAA, '0, RUN_BG), STS_OK,
			22'h2AAAAA, 5'd3, RUN_BG);
		dir_rows[11] = fixed(mk_cmd(MODE_FINDJ, '0, 5'd31, RUN_UNDEF), STS_NOTFOUND, '0, '0, '0);
		dir_rows[12] = fixed(mk_cmd(MODE_FINDJ, '0, 5'd17, RUN_UNDEF), STS_NOTFOUND, '0, '0, '0);
		dir_rows[13] = chk(mk_cmd(MODE_FINDJ, '0, 5'd16, RUN_STOP));
		dir_rows[14] = chk(mk_cmd(MODE_FINDP, 22'h3FFFFF, '0, RUN_UNDEF));
		dir_rows[15] = chk(mk_cmd(MODE_SETP, 22'd1, '0, RUN_FG));
		dir_rows[16] = chk(mk_cmd(MODE_FG, '0, '0, RUN_UNDEF));
		dir_rows[17] = chk(mk_cmd(MODE_SETJ, '0, 5'd1, RUN_UNDEF));
		dir_rows[18] = chk(mk_cmd(MODE_FG, '0, '0, RUN_UNDEF));
		dir_rows[19] = fixed(mk_cmd(MODE_DEL, 22'h155555, '0, RUN_UNDEF), STS_NOTFOUND,
			'0, '0, '0);
		dir_rows[20] = chk(mk_cmd(MODE_ADD, 22'd1, '0, RUN_BG));
		dir_rows[21] = chk(mk_cmd(MODE_LIST, '0, '0, RUN_UNDEF));
		dir_rows[22] = chk(mk_cmd(MODE_DEL, 22'h3FFFFF, '0, RUN_UNDEF));
		dir_rows[23] = chk(mk_cmd(MODE_DEL, 22'd1, '0, RUN_UNDEF));
		dir_rows[24] = chk(mk_cmd(MODE_LIST, '0, '0, RUN_UNDEF));

		pid_pool[0] = 22'd1;
		pid_pool[1] = 22'h3FFFFF;
		pid_pool[2] = 22'h2AAAAA;
		pid_pool[3] = 22'h155555;
		for (int i = 4; i < 12; i++) pid_pool[i] = PROC_W'($urandom_range(4194303, 1));

		jt_clear();
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIRECTED; i++) send_cmd(dir_rows[i]);
		for (int i = 0; i < N_RANDOM; i++) begin
			calm_tx = (i >= 35 && i < 60);
			send_cmd(chk(random_cmd(i)));
		end
		s_tvalid <= 1'b0;

		while (replies_due.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Ran %0d commands (%0d directed), %0d replies checked, %0d list commands,",
			n_cmds, N_DIRECTED, n_replies, n_lists);
		$display("%0d adds refused on a full table, %0d mismatches.", n_full, errors);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// File: files.f
hdl/jta_pkg.sv
hdl/jta_table_mem.sv
hdl/jta_seq.sv
hdl/job_table_with_id_allocation_unit.sv
tb/sv/job_table_with_id_allocation_unit_tb.sv
